// ===== src/sorted_key_table_macros.svh =====
// assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define SKT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define SKT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SKT_ASSERT(label, clk, rstn, prop)
`define SKT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/skt_pkg.sv =====
// shared types and constants of the sorted key table
package skt_pkg;
    localparam int DEPTH_DEF = 256;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W = 9;
    localparam int INDEX_W = 8;
    localparam int OP_W = 3;
    localparam int ADDR_W = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd4;

    localparam logic [ADDR_W-1:0] REG_CAPACITY = 3'd0;
    localparam logic [ADDR_W-1:0] REG_SIGNED   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_LK_RD,
        ST_LK_CMP,
        ST_GAP,
        ST_SO_RDI,
        ST_SO_RDJ,
        ST_SO_CMP,
        ST_SO_PUT,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic start;      // latch op/key, set up
        logic clear;
        logic append;
        logic ins_rd;     // read store at i-1
        logic ins_shift;  // store[i]=rd, i--
        logic ins_place;  // store[i]=key
        logic lk_rd;      // read mid
        logic lk_hit;
        logic lk_lo;
        logic lk_hi;
        logic gap_init;
        logic gap_next;
        logic so_rdi;     // read store[i], for so_latch_v to take into v
        logic so_latch_v;
        logic so_rdj;     // read store[j-gap]
        logic so_shift;   // store[j]=rd, j-=gap
        logic so_put;     // store[j]=v, i++
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic can_add;    // count below capacity now
        logic ins_more;   // i>0
        logic ins_gt;     // rd > key
        logic lk_more;    // hi>lo
        logic lk_eq;
        logic lk_gt;      // key > rd
        logic gap_first;  // gap still growing
        logic gap_one;
        logic so_i_more;  // i<n
        logic so_j_ok;    // j>=gap
        logic so_j2_ok;   // j>=2*gap
        logic so_lt;      // v < rd
    } status_t;
endpackage

// ===== src/skt_ctrl.sv =====
// controller state machine of the sorted key table
`include "sorted_key_table_macros.svh"
module skt_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [skt_pkg::OP_W-1:0]   s_op,
    input  logic                       out_free,
    output skt_pkg::cmd_t              cmd,
    input  skt_pkg::status_t           sts
);
    skt_pkg::state_t state_reg, state_next;
    logic [skt_pkg::OP_W-1:0] op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skt_pkg::ST_IDLE;
            op_reg    <= skt_pkg::OP_CLEAR;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            skt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start = 1'b1;
                    op_next = s_op;
                    case (s_op)
                        skt_pkg::OP_CLEAR: begin
                            cmd.clear = 1'b1;
                            state_next = skt_pkg::ST_DONE;
                        end
                        skt_pkg::OP_APPEND: begin
                            cmd.append = sts.can_add;
                            state_next = skt_pkg::ST_DONE;
                        end
                        skt_pkg::OP_INSERT: state_next = skt_pkg::ST_INS_RD;
                        skt_pkg::OP_LOOKUP: state_next = skt_pkg::ST_LK_RD;
                        skt_pkg::OP_SORT: state_next = skt_pkg::ST_GAP;
                        default: state_next = skt_pkg::ST_DONE;
                    endcase
                end
            end
            skt_pkg::ST_INS_RD: begin
                if (sts.full) begin
                    state_next = skt_pkg::ST_DONE;
                end else if (sts.ins_more) begin
                    cmd.ins_rd = 1'b1;
                    state_next = skt_pkg::ST_INS_CMP;
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next = skt_pkg::ST_DONE;
                end
            end
            skt_pkg::ST_INS_CMP: begin
                if (sts.ins_gt) begin
                    cmd.ins_shift = 1'b1;
                    state_next = skt_pkg::ST_INS_RD;
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next = skt_pkg::ST_DONE;
                end
            end
            skt_pkg::ST_LK_RD: begin
                if (sts.lk_more) begin
                    cmd.lk_rd = 1'b1;
                    state_next = skt_pkg::ST_LK_CMP;
                end else begin
                    state_next = skt_pkg::ST_DONE;
                end
            end
            skt_pkg::ST_LK_CMP: begin
                if (sts.lk_eq) begin
                    cmd.lk_hit = 1'b1;
                    state_next = skt_pkg::ST_DONE;
                end else begin
                    cmd.lk_lo = sts.lk_gt;
                    cmd.lk_hi = !sts.lk_gt;
                    state_next = skt_pkg::ST_LK_RD;
                end
            end
            skt_pkg::ST_GAP: begin
                // grow the gap past n, then step it down
                if (sts.gap_first) begin
                    cmd.gap_init = 1'b1;
                end else if (sts.gap_one) begin
                    state_next = skt_pkg::ST_DONE;
                end else begin
                    cmd.gap_next = 1'b1;
                    state_next = skt_pkg::ST_SO_RDI;
                end
            end
            skt_pkg::ST_SO_RDI: begin
                if (sts.so_i_more) begin
                    cmd.so_rdi = 1'b1;
                    state_next = skt_pkg::ST_SO_RDJ;
                end else begin
                    state_next = skt_pkg::ST_GAP;
                end
            end
            skt_pkg::ST_SO_RDJ: begin
                if (op_reg == skt_pkg::OP_SORT) begin
                    cmd.so_latch_v = 1'b1;
                end
                if (sts.so_j_ok) begin
                    cmd.so_rdj = 1'b1;
                    state_next = skt_pkg::ST_SO_CMP;
                end else begin
                    state_next = skt_pkg::ST_SO_PUT;
                end
            end
            skt_pkg::ST_SO_CMP: begin
                if (sts.so_lt) begin
                    cmd.so_shift = 1'b1;
                    state_next = skt_pkg::ST_SO_PUT;
                    if (sts.so_j2_ok) state_next = skt_pkg::ST_SO_CMP;
                end else begin
                    state_next = skt_pkg::ST_SO_PUT;
                end
            end
            skt_pkg::ST_SO_PUT: begin
                cmd.so_put = 1'b1;
                state_next = skt_pkg::ST_SO_RDI;
            end
            skt_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = skt_pkg::ST_IDLE;
                end
            end
            default: state_next = skt_pkg::ST_IDLE;
        endcase
    end

    `SKT_ASSERT(a_ready_idle, aclk, aresetn, s_ready |-> state_reg == skt_pkg::ST_IDLE)
    `SKT_ASSERT(a_out_from_done, aclk, aresetn,
        cmd.out_load |-> state_reg == skt_pkg::ST_DONE)
    `SKT_ASSERT(a_start_leaves, aclk, aresetn,
        (s_valid && s_ready) |=> state_reg != skt_pkg::ST_IDLE)
endmodule

// ===== src/skt_dp.sv =====
// datapath of the sorted key table: key store, indexes and compare
module skt_dp #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [skt_pkg::VALUE_W-1:0]   s_value,
    input  logic [skt_pkg::CAP_W-1:0]     capacity,
    input  logic                          signed_keys,
    input  skt_pkg::cmd_t                 cmd,
    output skt_pkg::status_t              sts,
    output logic                          out_valid,
    input  logic                          out_taken,
    output logic                          out_free,
    output logic                          out_found,
    output logic [skt_pkg::INDEX_W-1:0]   out_index,
    output logic [skt_pkg::CAP_W-1:0]     out_fill
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;   // counts 0..DEPTH
    localparam int GW = CW + 2;   // gap may exceed count by about 3x
    // inverse of 3 modulo 2**GW: exact division of gap - 1, a multiple of 3
    localparam logic [GW-1:0] INV3 =
        GW'(((GW % 2 == 1) ? (2**GW + 1) : (2**(GW + 1) + 1)) / 3);

    logic [KEY_WIDTH-1:0] mem [DEPTH];
    logic [KEY_WIDTH-1:0] rd_reg, key_reg, v_reg;
    logic [CW-1:0] count_reg, i_reg, j_reg, lo_reg, hi_reg, n_reg;
    logic [GW-1:0] gap_reg;
    logic [GW-1:0] gap_dec;
    logic          gap_grown_reg, full_reg;
    logic          hit_reg, found_reg, valid_reg;
    logic [skt_pkg::INDEX_W-1:0] hit_index_reg, index_reg;
    logic [skt_pkg::CAP_W-1:0] fill_reg;
    logic [CW-1:0] cap_eff, mid;
    logic [CW:0]   lohi;
    logic [KEY_WIDTH-1:0] key_in;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic          rd_en;

    function automatic logic less(input logic [KEY_WIDTH-1:0] a, input logic [KEY_WIDTH-1:0] b,
                                  input logic sgn);
        logic [KEY_WIDTH-1:0] x, y;
        x = a;
        y = b;
        if (sgn) begin
            x[KEY_WIDTH-1] = ~a[KEY_WIDTH-1];
            y[KEY_WIDTH-1] = ~b[KEY_WIDTH-1];
        end
        return x < y;
    endfunction

    assign key_in = KEY_WIDTH'(s_value);

    always_comb begin
        cap_eff = CW'(capacity);
        if (capacity == '0) cap_eff = CW'(1);
        if (int'(capacity) > DEPTH) cap_eff = CW'(DEPTH);
    end

    assign lohi = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = lohi[CW:1];
    assign gap_dec = GW'((gap_reg - GW'(1)) * INV3);

    // one write and one read a cycle
    always_comb begin
        wr_en = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = key_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        if (cmd.append) begin
            wr_en = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_data = key_in;
        end else if (cmd.ins_shift) begin
            wr_en = 1'b1;
            wr_addr = i_reg[AW-1:0];
            wr_data = rd_reg;
        end else if (cmd.ins_place) begin
            wr_en = 1'b1;
            wr_addr = i_reg[AW-1:0];
            wr_data = key_reg;
        end else if (cmd.so_shift) begin
            wr_en = 1'b1;
            wr_addr = j_reg[AW-1:0];
            wr_data = rd_reg;
        end else if (cmd.so_put) begin
            wr_en = 1'b1;
            wr_addr = j_reg[AW-1:0];
            wr_data = v_reg;
        end
        if (cmd.ins_rd) begin
            rd_en = 1'b1;
            rd_addr = AW'(i_reg - CW'(1));
        end else if (cmd.lk_rd) begin
            rd_en = 1'b1;
            rd_addr = mid[AW-1:0];
        end else if (cmd.so_rdi) begin
            rd_en = 1'b1;
            rd_addr = i_reg[AW-1:0];
        end else if (cmd.so_rdj || (cmd.so_shift && sts.so_j2_ok)) begin
            rd_en = 1'b1;
            rd_addr = cmd.so_shift ? AW'(GW'(j_reg) - gap_reg - gap_reg)
                                   : AW'(GW'(j_reg) - gap_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg <= key_in;
            full_reg <= count_reg >= cap_eff;
            i_reg <= count_reg;
            lo_reg <= '0;
            hi_reg <= count_reg;
            n_reg <= count_reg;
            gap_reg <= GW'(1);
            gap_grown_reg <= 1'b0;
        end
        if (cmd.ins_shift) i_reg <= i_reg - CW'(1);
        if (cmd.lk_lo) lo_reg <= mid + CW'(1);
        if (cmd.lk_hi) hi_reg <= mid;
        if (cmd.gap_init) begin
            if (gap_reg <= GW'(n_reg)) gap_reg <= gap_reg * GW'(3) + GW'(1);
            else gap_grown_reg <= 1'b1;
        end
        if (cmd.gap_next) begin
            gap_reg <= gap_dec;
            i_reg <= CW'(gap_dec);
        end
        if (cmd.so_rdi) j_reg <= i_reg;
        if (cmd.so_latch_v) v_reg <= rd_reg;
        if (cmd.so_shift) j_reg <= j_reg - CW'(gap_reg);
        if (cmd.so_put) i_reg <= i_reg + CW'(1);
    end

    always_comb begin
        sts.full = full_reg;
        sts.can_add = count_reg < cap_eff;
        sts.ins_more = i_reg != '0;
        sts.ins_gt = less(key_reg, rd_reg, signed_keys);
        sts.lk_more = hi_reg > lo_reg;
        sts.lk_eq = key_reg == rd_reg;
        sts.lk_gt = less(rd_reg, key_reg, signed_keys);
        sts.gap_first = !gap_grown_reg;
        sts.gap_one = gap_reg == GW'(1);
        sts.so_i_more = i_reg < n_reg;
        sts.so_j_ok = GW'(j_reg) >= gap_reg;
        sts.so_j2_ok = GW'(j_reg) >= gap_reg + gap_reg;
        sts.so_lt = less(v_reg, rd_reg, signed_keys);
    end

    // fill count and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
            hit_reg <= 1'b0;
            hit_index_reg <= '0;
            found_reg <= 1'b0;
            index_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (cmd.clear) count_reg <= '0;
            if (cmd.append || cmd.ins_place) count_reg <= count_reg + CW'(1);
            if (cmd.start) begin
                hit_reg <= 1'b0;
                hit_index_reg <= '0;
            end
            if (cmd.lk_hit) begin
                hit_reg <= 1'b1;
                hit_index_reg <= skt_pkg::INDEX_W'(mid);
            end
            // result held apart from the working state of the next item
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
                found_reg <= hit_reg;
                index_reg <= hit_index_reg;
                fill_reg <= skt_pkg::CAP_W'(count_reg);
            end else if (out_taken) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_free = !valid_reg || out_taken;
    assign out_valid = valid_reg;
    assign out_found = found_reg;
    assign out_index = index_reg;
    assign out_fill = fill_reg;
endmodule

// ===== src/sorted_key_table.sv =====
// sorted key table: append, sorted insert, binary search lookup, shell sort
// insert shifts each larger entry up one place, then writes the key; lookup halves its range at
// each probe; sort makes an insertion pass per gap, moving keys gap places at a time; an
// append or insert at a full table changes nothing and is flagged as rejected
// one item in work at a time; reset (aresetn, synchronous, active low) empties the table
// result is registered: the next item is taken while a result waits
module sorted_key_table #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [skt_pkg::OP_W-1:0]      s_op,
    input  logic [skt_pkg::VALUE_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [skt_pkg::INDEX_W-1:0]   m_index,
    output logic                          m_rejected,
    output logic [skt_pkg::CAP_W-1:0]     m_fill_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [skt_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    skt_pkg::cmd_t    cmd;
    skt_pkg::status_t sts;
    logic [skt_pkg::CAP_W-1:0] capacity_reg;
    logic signed_reg, out_free;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= skt_pkg::CAP_W'(256);
            signed_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                skt_pkg::REG_CAPACITY: capacity_reg <= pwdata[skt_pkg::CAP_W-1:0];
                skt_pkg::REG_SIGNED: signed_reg <= pwdata[0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr)
            skt_pkg::REG_CAPACITY: prdata = {{(32-skt_pkg::CAP_W){1'b0}}, capacity_reg};
            skt_pkg::REG_SIGNED: prdata = {31'd0, signed_reg};
            default: prdata = '0;
        endcase
    end

    skt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .out_free(out_free), .cmd(cmd), .sts(sts)
    );

    skt_dp #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_value(s_value), .capacity(capacity_reg),
        .signed_keys(signed_reg), .cmd(cmd), .sts(sts), .out_valid(m_valid),
        .out_taken(m_ready), .out_free(out_free), .out_found(m_found),
        .out_index(m_index), .out_fill(m_fill_count)
    );

    // rejected flag, loaded with the result and held beside it
    logic rej_reg, op_is_add_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rej_reg <= 1'b0;
            op_is_add_reg <= 1'b0;
        end else if (cmd.start) begin
            op_is_add_reg <= s_op == skt_pkg::OP_APPEND || s_op == skt_pkg::OP_INSERT;
        end else if (cmd.out_load) begin
            rej_reg <= op_is_add_reg && sts.full;
        end
    end
    assign m_rejected = rej_reg;
endmodule
